// File: hw/rtl/battery_soc_display_remap_core_defines.svh
// assertion macros for the display remap core
`ifndef BATTERY_SOC_DISPLAY_REMAP_CORE_DEFINES_SVH
`define BATTERY_SOC_DISPLAY_REMAP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication on clk_i, off during reset
`define BSDR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication on clk_i, off during reset
`define BSDR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSDR_ASSERT_IMP(label, ante, cons, msg)
`define BSDR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/bsdr_pkg.sv
package bsdr_pkg;

  // field widths
  localparam int unsigned ThrW  = 7;
  localparam int unsigned LvlW  = 8;
  localparam int unsigned SocW  = 8;
  localparam int unsigned CapW  = 16;

  // configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgLowThreshold     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRechargeThreshold = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgLowBatteryLevel  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgFullLevel        = CfgIdxW'(3);

  // register reset values
  localparam logic [ThrW-1:0] RstLowThreshold      = ThrW'(5);
  localparam logic [ThrW-1:0] RstRechargeThreshold = ThrW'(95);
  localparam logic [LvlW-1:0] RstLowBatteryLevel   = LvlW'(1);
  localparam logic [LvlW-1:0] RstFullLevel         = LvlW'(100);

  // shared divider sizing: dividend is a 16x8 product, divisor fits 17 bits
  localparam int unsigned DividendW = CapW + LvlW;
  localparam int unsigned DivisorW  = CapW + 1;
  localparam int unsigned DivCycles = DividendW / 2;
  localparam int unsigned DivCntW   = $clog2(DivCycles);

  localparam logic [DivisorW-1:0] PctScale = DivisorW'(100);

  typedef struct packed {
    logic [ThrW-1:0] low_threshold;
    logic [ThrW-1:0] recharge_threshold;
    logic [LvlW-1:0] low_battery_level;
    logic [LvlW-1:0] full_level;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic [SocW-1:0] gauge_soc;
    logic [CapW-1:0] full_charge_cap;
    logic [CapW-1:0] remaining_cap;
    logic            battery_full;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic [LvlW-1:0] display_soc;
  } res_t;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DividendW-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/bsdr_in_if.sv
interface bsdr_in_if;
  import bsdr_pkg::*;

  logic            valid;
  logic            ready;
  logic            kind;
  logic [SocW-1:0] gauge_soc;
  logic [CapW-1:0] full_charge_cap;
  logic [CapW-1:0] remaining_cap;
  logic            battery_full;

  modport source (
    output valid, kind, gauge_soc, full_charge_cap, remaining_cap, battery_full,
    input  ready
  );

  modport sink (
    input  valid, kind, gauge_soc, full_charge_cap, remaining_cap, battery_full,
    output ready
  );
endinterface

// File: hw/rtl/bsdr_out_if.sv
interface bsdr_out_if;
  import bsdr_pkg::*;

  logic            valid;
  logic            ready;
  logic [LvlW-1:0] display_soc;

  modport source (
    output valid, display_soc,
    input  ready
  );

  modport sink (
    input  valid, display_soc,
    output ready
  );
endinterface

// File: hw/rtl/bsdr_cfg_if.sv
interface bsdr_cfg_if;
  import bsdr_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: hw/rtl/battery_soc_display_remap_core.sv
// Display remap core: turns a fuel-gauge state of charge into the level shown
// to the user. Three valid/ready channels: in_i takes a remap request or a
// boot status event, out_o returns one display level per remap request (none
// for a boot event), cfg_i writes the four threshold and level registers.
// Configuration is to be written only while the block is idle; the block
// does not enforce this, and cfg_i is always ready. A reading in the low or
// high region is settled in the decode state and goes straight to emit; in
// the middle band one 16x8 multiplier and one two-bit-per-cycle divider are
// reused for the band bottom, the band top and the final scaling (the last
// is skipped when the band is degenerate). A boot event returns in_i to ready
// after the decode state. One item is worked on at a time; in_i is not ready
// meanwhile, so no new item is taken until the last one is done.
// The result sits in an output register, so a new item is taken while a
// result still waits; if out_o stalls, the next result holds in the
// sequencer until the register frees up.
// Reset loads the register defaults (thresholds 5 and 95, low level 1, full
// level 100) and clears the extra-step flag.
`include "battery_soc_display_remap_core_defines.svh"

module battery_soc_display_remap_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  bsdr_in_if.sink           in_i,
  bsdr_out_if.source        out_o,
  bsdr_cfg_if.sink          cfg_i
);
  import bsdr_pkg::*;

  cfg_t            cfg_q;
  item_t           item;
  res_t            res;
  logic            res_ready;
  logic            item_ready;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  logic            out_valid_q;
  logic [LvlW-1:0] display_soc_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold      <= RstLowThreshold;
      cfg_q.recharge_threshold <= RstRechargeThreshold;
      cfg_q.low_battery_level  <= RstLowBatteryLevel;
      cfg_q.full_level         <= RstFullLevel;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgLowThreshold:      cfg_q.low_threshold      <= cfg_i.data[ThrW-1:0];
        CfgRechargeThreshold: cfg_q.recharge_threshold <= cfg_i.data[ThrW-1:0];
        CfgLowBatteryLevel:   cfg_q.low_battery_level  <= cfg_i.data[LvlW-1:0];
        CfgFullLevel:         cfg_q.full_level         <= cfg_i.data[LvlW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input request unpacking
  assign item.kind            = in_i.kind;
  assign item.gauge_soc       = in_i.gauge_soc;
  assign item.full_charge_cap = in_i.full_charge_cap;
  assign item.remaining_cap   = in_i.remaining_cap;
  assign item.battery_full    = in_i.battery_full;
  assign in_i.ready           = item_ready;

  bsdr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (in_i.valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

  bsdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // output register
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      display_soc_q <= res.display_soc;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.display_soc = display_soc_q;

  // checks
  `BSDR_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "not busy")
  `BSDR_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider started busy")
  `BSDR_ASSERT_IMP(a_div_done_busy, div_rsp.done, !in_i.ready, "quotient while idle")

endmodule

// File: hw/rtl/bsdr_div.sv
module bsdr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsdr_pkg::div_req_t req_i,
  output bsdr_pkg::div_rsp_t rsp_o
);
  import bsdr_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  den_q, den_d;
  logic [DivisorW-1:0]  rem_mid;
  logic [DividendW-1:0] quo_mid;
  logic [DivisorW-1:0]  rem_nxt;
  logic [DividendW-1:0] quo_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [DivisorW+DividendW-1:0] div_step(
    input logic [DivisorW-1:0]  rem,
    input logic [DividendW-1:0] quo,
    input logic [DivisorW-1:0]  den
  );
    logic [DivisorW:0] part;
    logic [DivisorW:0] diff;
    logic              fits;
    part = {rem, quo[DividendW-1]};
    diff = part - {1'b0, den};
    fits = (part >= {1'b0, den});
    if (fits) begin
      return {diff[DivisorW-1:0], quo[DividendW-2:0], 1'b1};
    end else begin
      return {part[DivisorW-1:0], quo[DividendW-2:0], 1'b0};
    end
  endfunction

  // two steps per cycle
  assign {rem_mid, quo_mid} = div_step(rem_q, quo_q, den_q);
  assign {rem_nxt, quo_nxt} = div_step(rem_mid, quo_mid, den_q);

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivCycles - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = rem_nxt;
      quo_d = quo_nxt;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: hw/rtl/bsdr_seq.sv
module bsdr_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsdr_pkg::cfg_t     cfg_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  bsdr_pkg::item_t    item_i,
  output bsdr_pkg::res_t     res_o,
  input  logic               res_ready_i,
  output bsdr_pkg::div_req_t div_req_o,
  input  bsdr_pkg::div_rsp_t div_rsp_i
);
  import bsdr_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StDecode  = 3'd1;
  localparam logic [2:0] StDivBot  = 3'd2;
  localparam logic [2:0] StMulTop  = 3'd3;
  localparam logic [2:0] StDivTop  = 3'd4;
  localparam logic [2:0] StCheck   = 3'd5;
  localparam logic [2:0] StDivSpan = 3'd6;
  localparam logic [2:0] StEmit    = 3'd7;

  logic [2:0]           state_q, state_d;
  item_t                item_q;
  logic                 flag_q, flag_d;
  logic [LvlW-1:0]      res_q, res_d;
  logic [DivisorW-1:0]  bottom_q, bottom_d;
  logic [DivisorW-1:0]  top_q, top_d;

  logic [LvlW-1:0]      band_top;
  logic [LvlW-1:0]      band_lo;
  logic [LvlW-1:0]      band_span;
  logic [LvlW-1:0]      band_width;
  logic                 soc_low;
  logic                 soc_high;
  logic                 soc_above;
  logic                 boot_set;
  logic [DivisorW-1:0]  rem_ext;
  logic [DivisorW-1:0]  rem_off;
  logic                 degen;
  logic                 clamp;
  logic [LvlW-1:0]      span_val;
  logic [CapW-1:0]      mul_a;
  logic [LvlW-1:0]      mul_b;

  // display band limits
  assign band_top   = (cfg_i.full_level == '0) ? '0 : cfg_i.full_level - LvlW'(1);
  assign band_lo    = (cfg_i.low_battery_level == '1) ? '1
                      : cfg_i.low_battery_level + LvlW'(1);
  assign band_width = band_top - band_lo;
  assign band_span  = band_width + LvlW'(1);

  // gauge soc classification
  assign soc_low   = item_q.gauge_soc <= {1'b0, cfg_i.low_threshold};
  assign soc_high  = item_q.gauge_soc >= {1'b0, cfg_i.recharge_threshold};
  assign soc_above = {1'b0, item_q.gauge_soc} >= ({2'b0, cfg_i.recharge_threshold} + 9'd1);
  assign boot_set  = (item_q.gauge_soc == {1'b0, cfg_i.recharge_threshold})
                     && !item_q.battery_full;

  // degenerate or inverted band
  assign rem_ext = {1'b0, item_q.remaining_cap};
  assign rem_off = rem_ext - bottom_q;
  assign degen   = (rem_ext < bottom_q) || (top_q <= bottom_q) || (band_top < band_lo);

  // linear map result with clamp to the band top
  assign clamp    = div_rsp_i.quotient > {{(DividendW-LvlW){1'b0}}, band_width};
  assign span_val = clamp ? band_top : band_lo + div_rsp_i.quotient[LvlW-1:0];

  // sequencer
  always_comb begin
    state_d   = state_q;
    flag_d    = flag_q;
    res_d     = res_q;
    bottom_d  = bottom_q;
    top_d     = top_q;
    mul_a     = item_q.full_charge_cap;
    mul_b     = '0;
    div_req_o.start   = 1'b0;
    div_req_o.divisor = PctScale;
    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (item_q.kind) begin
          if (boot_set) begin
            flag_d = 1'b1;
          end
          state_d = StIdle;
        end else if (soc_low) begin
          res_d   = (item_q.gauge_soc == '0) ? '0 : cfg_i.low_battery_level;
          state_d = StEmit;
        end else if (soc_high) begin
          if (flag_q && soc_above) begin
            res_d  = cfg_i.full_level;
            flag_d = 1'b0;
          end else if (flag_q) begin
            res_d = band_top;
          end else begin
            res_d = cfg_i.full_level;
          end
          state_d = StEmit;
        end else begin
          // capacity at the low threshold
          mul_b           = {1'b0, cfg_i.low_threshold};
          div_req_o.start = 1'b1;
          state_d         = StDivBot;
        end
      end
      StDivBot: begin
        if (div_rsp_i.done) begin
          bottom_d = div_rsp_i.quotient[DivisorW-1:0];
          state_d  = StMulTop;
        end
      end
      StMulTop: begin
        // capacity one step below the recharge threshold
        mul_b           = {1'b0, cfg_i.recharge_threshold - ThrW'(1)};
        div_req_o.start = 1'b1;
        state_d         = StDivTop;
      end
      StDivTop: begin
        if (div_rsp_i.done) begin
          top_d   = div_rsp_i.quotient[DivisorW-1:0];
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (degen) begin
          res_d = band_lo;
          if (band_lo == band_top) begin
            flag_d = 1'b1;
          end
          state_d = StEmit;
        end else begin
          mul_a             = rem_off[CapW-1:0];
          mul_b             = band_span;
          div_req_o.divisor = top_q - bottom_q;
          div_req_o.start   = 1'b1;
          state_d           = StDivSpan;
        end
      end
      StDivSpan: begin
        if (div_rsp_i.done) begin
          res_d = span_val;
          if (span_val == band_top) begin
            flag_d = 1'b1;
          end
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // shared multiplier feeding the divider
    div_req_o.dividend = {{LvlW{1'b0}}, mul_a} * {{CapW{1'b0}}, mul_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
    end
  end

  // item capture and working registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && item_valid_i) begin
      item_q <= item_i;
    end
    res_q    <= res_d;
    bottom_q <= bottom_d;
    top_q    <= top_d;
  end

  assign item_ready_o      = (state_q == StIdle);
  assign res_o.valid       = (state_q == StEmit);
  assign res_o.display_soc = res_q;

endmodule
